FILE: src/salc_pkg.sv
`timescale 1ns / 1ps

package salc_pkg;

    // ways_mode codes
    localparam logic MODE_2WAY = 1'b0;
    localparam logic MODE_4WAY = 1'b1;
    localparam logic MODE_RESET = MODE_4WAY;

    // one memory row holds the widest set
    localparam int WAYS_MAX = 4;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } salc_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic lookup_rd;
        logic commit;
    } salc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } salc_status_t;

endpackage

FILE: src/salc_ctrl.sv
`timescale 1ns / 1ps

module salc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  salc_pkg::salc_status_t status,
    output salc_pkg::salc_cmd_t    cmd
);
    import salc_pkg::*;

    salc_state_t state_reg;
    salc_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    // state and output slot registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd.clear_wr  = 1'b0;
        cmd.lookup_rd = 1'b0;
        cmd.commit    = 1'b0;
        in_stall      = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.lookup_rd = 1'b1;
                    state_next    = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // write back only when the output slot is free or draining
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        out_valid_next = cmd.commit | (out_valid_reg & out_stall);
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: src/salc_datapath.sv
`timescale 1ns / 1ps

module salc_datapath #(
    parameter int OFFSET_BITS = 2,
    parameter int TOTAL_LINES = 32768,
    parameter int ADDR_WIDTH  = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_data,
    input  logic [31:0]            address,
    input  salc_pkg::salc_cmd_t    cmd,
    output salc_pkg::salc_status_t status,
    output logic                   hit,
    output logic [31:0]            miss_address,
    output logic [31:0]            hit_total,
    output logic [31:0]            miss_total
);
    import salc_pkg::*;

    localparam int AW      = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
    localparam logic [31:0] ADDR_MASK = 32'((64'd1 << AW) - 64'd1);
    localparam int LG      = $clog2(TOTAL_LINES + 1) - 1;
    localparam int ROW_W   = LG - 2;
    localparam int ROWS    = 1 << ROW_W;
    localparam int SH4     = OFFSET_BITS + LG - 2;
    localparam int SH2     = OFFSET_BITS + LG - 1;
    localparam int TAG_RAW = AW - SH4;
    localparam int TAG_W   = (TAG_RAW < 1) ? 1 : TAG_RAW;
    localparam int ENT_W   = TAG_W + 1;

    typedef logic [WAYS_MAX-1:0][ENT_W-1:0] row_t;

    // one row per 4-way set, or two 2-way sets side by side
    row_t mem [ROWS];

    logic             mode_reg;
    logic [ROW_W-1:0] clr_row_reg;
    logic [31:0]      addr_reg;
    row_t             rd_data_reg;
    logic             hit_reg;
    logic [31:0]      miss_addr_reg;
    logic [31:0]      hits_reg;
    logic [31:0]      misses_reg;

    logic [31:0]      addr_in;
    logic [ROW_W-1:0] row_in;
    logic [ROW_W-1:0] row_cur;
    logic             half;
    logic [31:0]      tag_shift;
    logic [TAG_W-1:0] tag_cur;
    row_t             sel;
    row_t             new_sel;
    row_t             wr_data;
    logic [WAYS_MAX-1:0] match;
    logic [1:0]       hit_way;
    logic [1:0]       k_stop;
    logic             any_hit;

    // read address from the incoming transfer
    always_comb
    begin
        addr_in = address & ADDR_MASK;
        if (mode_reg == MODE_4WAY)
        begin
            row_in = addr_in[OFFSET_BITS +: ROW_W];
        end
        else
        begin
            row_in = addr_in[OFFSET_BITS + 1 +: ROW_W];
        end
    end

    // tag compare and recency reorder of the fetched set
    always_comb
    begin
        half = addr_reg[OFFSET_BITS];
        if (mode_reg == MODE_4WAY)
        begin
            row_cur   = addr_reg[OFFSET_BITS +: ROW_W];
            tag_shift = addr_reg >> SH4;
            sel       = rd_data_reg;
        end
        else
        begin
            row_cur   = addr_reg[OFFSET_BITS + 1 +: ROW_W];
            tag_shift = addr_reg >> SH2;
            sel       = rd_data_reg;
            sel[0]    = rd_data_reg[{half, 1'b0}];
            sel[1]    = rd_data_reg[{half, 1'b1}];
        end
        tag_cur = tag_shift[TAG_W-1:0];

        for (int j = 0; j < WAYS_MAX; j++)
        begin
            match[j] = sel[j][ENT_W-1] && (sel[j][TAG_W-1:0] == tag_cur)
                       && ((mode_reg == MODE_4WAY) || (j < 2));
        end

        // first matching way wins
        hit_way = 2'd0;
        for (int j = WAYS_MAX - 1; j >= 0; j--)
        begin
            if (match[j])
            begin
                hit_way = 2'(j);
            end
        end
        any_hit = |match;

        if (any_hit)
        begin
            k_stop = hit_way;
        end
        else if (mode_reg == MODE_4WAY)
        begin
            k_stop = 2'd3;
        end
        else
        begin
            k_stop = 2'd1;
        end

        new_sel[0] = {1'b1, tag_cur};
        for (int j = 1; j < WAYS_MAX; j++)
        begin
            if (2'(j) <= k_stop)
            begin
                new_sel[j] = sel[j-1];
            end
            else
            begin
                new_sel[j] = sel[j];
            end
        end

        if (mode_reg == MODE_4WAY)
        begin
            wr_data = new_sel;
        end
        else
        begin
            wr_data                = rd_data_reg;
            wr_data[{half, 1'b0}] = new_sel[0];
            wr_data[{half, 1'b1}] = new_sel[1];
        end
    end

    // line store: clearing sweep, set read, set write back
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            mem[clr_row_reg] <= '0;
        end
        else if (cmd.commit)
        begin
            mem[row_cur] <= wr_data;
        end
        if (cmd.lookup_rd)
        begin
            rd_data_reg <= mem[row_in];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.lookup_rd)
        begin
            addr_reg <= addr_in;
        end
        if (cmd.commit)
        begin
            hit_reg       <= any_hit;
            miss_addr_reg <= addr_reg;
        end
    end

    // mode, clear counter and saturating hit/miss counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RESET;
            clr_row_reg <= '0;
            hits_reg    <= '0;
            misses_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
            if (cmd.clear_wr)
            begin
                clr_row_reg <= clr_row_reg + ROW_W'(1);
            end
            if (cmd.commit)
            begin
                if (any_hit && (hits_reg != '1))
                begin
                    hits_reg <= hits_reg + 32'd1;
                end
                if (!any_hit && (misses_reg != '1))
                begin
                    misses_reg <= misses_reg + 32'd1;
                end
            end
        end
    end

    assign status.clear_last = (clr_row_reg == '1);
    assign hit               = hit_reg;
    assign miss_address      = miss_addr_reg;
    assign hit_total         = hits_reg;
    assign miss_total        = misses_reg;

endmodule

FILE: src/set_assoc_lru_cache_tag_check.sv
`timescale 1ns / 1ps
// Tag check of a 2-way or 4-way set-associative cache with true LRU order.
// Input channel: in_valid / in_stall with one byte address per transfer.
// Output channel: out_valid / out_stall carrying hit, the echoed address
// (miss_address) and the saturating hit and miss totals after this access.
// Config channel: cfg_valid / cfg_ready, cfg_data is ways_mode
// (0 = 2-way, 1 = 4-way); write it only while no access is in flight.
// Each access is one registered read of the set's memory row, then tag
// compare and write back of the reordered row, held while the result slot is stalled.
// A new address is not taken until the previous access has written back;
// the result is registered in the output slot at write back.
// A result waits in the output register while out_stall is high; one more
// address is taken meanwhile, but its write back holds until the slot frees.
// After reset the line store is swept to invalid one row per cycle, all
// 2**(log2(TOTAL_LINES)-2) rows (8192 by default), with in_stall high;
// config writes are taken during the sweep. Counters reset to zero.
module set_assoc_lru_cache_tag_check #(
    parameter int OFFSET_BITS = 2,
    parameter int TOTAL_LINES = 32768,
    parameter int ADDR_WIDTH  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic [31:0] miss_address,
    output logic [31:0] hit_total,
    output logic [31:0] miss_total
);
    import salc_pkg::*;

    salc_cmd_t    cmd;
    salc_status_t status;

    // config register is always writable
    assign cfg_ready = 1'b1;

    salc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    salc_datapath #(
        .OFFSET_BITS (OFFSET_BITS),
        .TOTAL_LINES (TOTAL_LINES),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .address      (address),
        .cmd          (cmd),
        .status       (status),
        .hit          (hit),
        .miss_address (miss_address),
        .hit_total    (hit_total),
        .miss_total   (miss_total)
    );

endmodule

FILE: dv/lru_tag_checker.sv
`timescale 1ns / 1ps

module lru_tag_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] address,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        hit,
    input  logic [31:0] miss_address,
    input  logic [31:0] hit_total,
    input  logic [31:0] miss_total,
    output int          mismatches,
    output int          outstanding
);
    import salc_pkg::*;

    localparam int OFFSET_BITS = 2;
    localparam int TOTAL_LINES = 32768;
    localparam int LINES_LOG2  = $clog2(TOTAL_LINES);

    typedef struct {
        logic        hit;
        logic [31:0] miss_address;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } access_result_t;

    // local copy of the tag array, way 0 of each set is the most recent
    logic           line_valid [TOTAL_LINES];
    logic [31:0]    line_tag   [TOTAL_LINES];
    logic           ways_mode;
    logic [31:0]    hit_count;
    logic [31:0]    miss_count;
    access_result_t results_due [$];
    int             errors;

    // look up one address, reorder its set and bump the totals
    function automatic access_result_t lru_access(input logic [31:0] addr);
        access_result_t r;
        int             ways;
        int             idx_bits;
        int             base;
        int             hit_way;
        int             w;
        logic [31:0]    tag;
        ways     = (ways_mode == MODE_4WAY) ? 4 : 2;
        idx_bits = LINES_LOG2 - ((ways_mode == MODE_4WAY) ? 2 : 1);
        base     = int'((addr >> OFFSET_BITS) & ((32'd1 << idx_bits) - 32'd1)) * ways;
        tag      = addr >> (OFFSET_BITS + idx_bits);

        // first valid way holding the tag; a stale wider tag never matches
        hit_way = ways;
        for (w = 0; w < ways; w++)
        begin
            if (hit_way == ways && line_valid[base + w] && line_tag[base + w] == tag)
                hit_way = w;
        end

        // ways ahead of the hit (or all on a miss) move down one slot
        for (w = (hit_way < ways) ? hit_way : ways - 1; w > 0; w--)
        begin
            line_valid[base + w] = line_valid[base + w - 1];
            line_tag[base + w]   = line_tag[base + w - 1];
        end
        line_valid[base] = 1'b1;
        line_tag[base]   = tag;

        // saturating totals
        if (hit_way < ways)
        begin
            if (hit_count != '1)
                hit_count++;
        end
        else if (miss_count != '1)
            miss_count++;

        r.hit          = (hit_way < ways);
        r.miss_address = addr;
        r.hit_total    = hit_count;
        r.miss_total   = miss_count;
        return r;
    endfunction

    function automatic int field_check(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        access_result_t want;
        int             i;
        if (!rst_n)
        begin
            for (i = 0; i < TOTAL_LINES; i++)
            begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
            end
            ways_mode  = MODE_RESET;
            hit_count  = '0;
            miss_count = '0;
            results_due.delete();
            errors = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // result transfer, matched against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual hit %b addr %h",
                             $time, hit, miss_address);
                    errors++;
                end
                else
                begin
                    want = results_due.pop_front();
                    errors += field_check("hit", 32'(want.hit), 32'(hit));
                    errors += field_check("miss_address", want.miss_address, miss_address);
                    errors += field_check("hit_total", want.hit_total, hit_total);
                    errors += field_check("miss_total", want.miss_total, miss_total);
                end
            end

            // mode write
            if (cfg_valid && cfg_ready)
                ways_mode = cfg_data;

            // address transfer
            if (in_valid && !in_stall)
                results_due.push_back(lru_access(address));

            mismatches  <= errors;
            outstanding <= results_due.size();
        end
    end

endmodule

FILE: dv/set_assoc_lru_cache_tag_check_test.sv
`timescale 1ns / 1ps

module set_assoc_lru_cache_tag_check_test;
    import salc_pkg::*;

    localparam int PHASE_ITEMS      = 262;
    localparam int LONG_HOLD_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] address;
    logic        out_valid;
    logic        out_stall;
    logic        hit;
    logic [31:0] miss_address;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    int          mismatches;
    int          outstanding;
    int          sent;
    int          received;
    logic        ways_sel;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    set_assoc_lru_cache_tag_check dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .address      (address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .miss_address (miss_address),
        .hit_total    (hit_total),
        .miss_total   (miss_total)
    );

    lru_tag_checker u_lru_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .address      (address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .miss_address (miss_address),
        .hit_total    (hit_total),
        .miss_total   (miss_total),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // build an address in the current layout from a tag and a set
    function automatic logic [31:0] line_address(input logic [31:0] tag,
                                                 input logic [31:0] set_num);
        int idx_bits;
        idx_bits = (ways_sel == MODE_4WAY) ? 13 : 14;
        return (tag << (idx_bits + 2))
             | ((set_num & ((32'd1 << idx_bits) - 32'd1)) << 2)
             | $urandom_range(0, 3);
    endfunction

    // one address transfer, with a random gap before it except in calm stretches
    task automatic send_address(input logic [31:0] a);
        int gap;
        gap = ((sent % 160) < 30) ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        address  <= a;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    // stop sending and wait for every result to come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_ways_mode(input logic m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ways_sel = m;
    endtask

    // mostly a few hot sets and tags so lines hit and get evicted, some noise
    task automatic random_phase(input int count);
        logic [31:0] hot_set [4];
        logic [31:0] hot_tag [6];
        int          i;
        int unsigned pick;
        for (i = 0; i < 4; i++)
            hot_set[i] = $urandom;
        for (i = 0; i < 6; i++)
            hot_tag[i] = $urandom;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 85)
                send_address($urandom);
            else
            begin
                if (pick >= 75)
                    hot_tag[$urandom_range(0, 5)] = $urandom;
                send_address(line_address(hot_tag[$urandom_range(0, 5)],
                                          hot_set[$urandom_range(0, 3)]));
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        logic [31:0] four_way_tags [10];
        logic [31:0] two_way_tags  [7];
        int          i;
        int          ph;
        four_way_tags = '{1, 2, 3, 4, 4, 2, 1, 2, 5, 3};
        two_way_tags  = '{7, 8, 7, 9, 8, 32'hFFFF, 32'hFFFF};
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        in_valid  <= 1'b0;
        address   <= '0;
        sent      = 0;
        ways_sel  = MODE_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // four-way: extremes, then fill one set and hit every recency slot
        set_ways_mode(MODE_4WAY);
        send_address(32'h0000_0000);
        send_address(32'hFFFF_FFFF);
        send_address(32'h0000_0000);
        for (i = 0; i < 10; i++)
            send_address(line_address(four_way_tags[i], 5));
        send_address(line_address(32'h1_FFFF, 5));
        drain();

        // two-way over what the four-way layout left behind
        set_ways_mode(MODE_2WAY);
        send_address(32'h0000_0000);
        send_address(line_address(32'hFFFF, 10));
        send_address(32'hFFFF_FFFF);
        for (i = 0; i < 7; i++)
            send_address(line_address(two_way_tags[i], 9));
        drain();

        // random phases alternating the layout
        for (ph = 0; ph < 4; ph++)
        begin
            if (ph > 0)
                set_ways_mode((ph % 2 == 1) ? MODE_4WAY : MODE_2WAY);
            random_phase(PHASE_ITEMS);
            drain();
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // result side: random stalls, calm stretches and two long hold-offs
    initial
    begin
        int hold;
        out_stall <= 1'b0;
        received  = 0;
        @(posedge clk);
        forever
        begin
            if (received == 200 || received == 700)
                hold = LONG_HOLD_CYCLES;
            else if ((received % 130) < 25)
                hold = 0;
            else
                hold = $urandom_range(0, 5);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            received++;
        end
    end

    // run limit
    initial
    begin
        #400000;
        $display("FAILURE");
        $finish;
    end

endmodule
